FILE: src/midi_note_duration_splitter_macros.svh
// ----------------------------------------------------------------------------
// MIDI note duration splitter: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_DURATION_SPLITTER_MACROS_SVH
`define MIDI_NOTE_DURATION_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MNDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mnds assertion failed");

// next-cycle implication, disabled while in reset
`define MNDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mnds assertion failed");

`endif

FILE: src/mnds_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: package
// Field widths, status codes, defaults and the queue entry type.
// ----------------------------------------------------------------------------
package mnds_pkg;

  localparam int STATUS_W     = 8;
  localparam int KEY_W        = 7;
  localparam int VEL_W        = 7;
  localparam int DELTA_W      = 28;
  localparam int TPQ_W        = 10;
  localparam int NOTE_VALUE_W = 4;
  localparam int DOTS_W       = 28;

  // whole note is four quarters; half of a base value is one bit narrower
  localparam int WHOLE_W = TPQ_W + 2;
  localparam int HALF_W  = WHOLE_W - 1;

  localparam logic [TPQ_W-1:0]        TPQ_RESET = 10'd384;
  localparam logic [DELTA_W-1:0]      LEN_MAX   = 28'h0FFFFFFF;
  localparam logic [NOTE_VALUE_W-1:0] MAX_SHIFT = 4'd15;

  // status classification
  localparam logic [STATUS_W-1:0] STATUS_KIND_MASK = 8'hF0;
  localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF  = 8'h80;
  localparam logic [STATUS_W-1:0] STATUS_NOTE_ON   = 8'h90;

  localparam int MAX_PARTS_DEF     = 16;
  localparam int GRANULE_TICKS_DEF = 48;
  localparam int QUEUE_DEPTH       = 2;

  // one classified event, handed from front to back
  typedef struct packed {
    logic               is_on;
    logic [KEY_W-1:0]   key;
    logic [DELTA_W-1:0] len;
  } cmd_t;

endpackage

FILE: src/mnds_ifs.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: channel interfaces
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mnds_in_if;
  logic                            valid;
  logic                            ready;
  logic [mnds_pkg::STATUS_W-1:0]   status_byte;
  logic [mnds_pkg::KEY_W-1:0]      key_number;
  logic [mnds_pkg::VEL_W-1:0]      velocity;
  logic [mnds_pkg::DELTA_W-1:0]    delta_ticks;

  modport source (output valid, status_byte, key_number, velocity, delta_ticks,
                  input ready);
  modport sink   (input valid, status_byte, key_number, velocity, delta_ticks,
                  output ready);
endinterface

interface mnds_out_if;
  logic                              valid;
  logic                              ready;
  logic                              is_rest;
  logic [mnds_pkg::KEY_W-1:0]        pitch;
  logic [mnds_pkg::NOTE_VALUE_W-1:0] note_value;
  logic [mnds_pkg::DOTS_W-1:0]       dot_count;
  logic                              last_part;

  modport source (output valid, is_rest, pitch, note_value, dot_count, last_part,
                  input ready);
  modport sink   (input valid, is_rest, pitch, note_value, dot_count, last_part,
                  output ready);
endinterface

interface mnds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mnds_pkg::TPQ_W-1:0] ticks_per_quarter;

  modport source (output valid, ticks_per_quarter, input ready);
  modport sink   (input valid, ticks_per_quarter, output ready);
endinterface

FILE: src/mnds_front.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: front end
// Accepts events, drops non-note statuses, rounds the delta to the granule
// with a reciprocal multiply and a scale, and queues the result.
// ----------------------------------------------------------------------------
module mnds_front #(
  parameter int GRANULE_TICKS = mnds_pkg::GRANULE_TICKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  mnds_in_if.sink        in_ch,
  output mnds_pkg::cmd_t push_data,
  output logic           push_valid,
  input  logic           push_ready
);

  // numerator 2*delta + G, divisor 2*G
  localparam int NUM_W   = mnds_pkg::DELTA_W + 2;
  localparam int DIV_VAL = 2 * GRANULE_TICKS;
  localparam int DIV_L   = $clog2(DIV_VAL);
  localparam int G_W     = $clog2(GRANULE_TICKS + 1);
  localparam int PROD_W  = NUM_W + G_W;

  // quotient = (num * RECIP) >> SHIFT, exact for every num below 2**NUM_W
  localparam int RECIP_W = NUM_W + 1;
  localparam int SHIFT   = NUM_W + DIV_L;
  localparam int PR_W    = NUM_W + RECIP_W;

  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(DIV_VAL) - 64'd1) / 64'(DIV_VAL);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_64);
  localparam logic [G_W-1:0]     G_CONST = G_W'(GRANULE_TICKS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [NUM_W-1:0]              num_r, num_nxt;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic                          is_on_r, is_on_nxt;
  logic [mnds_pkg::KEY_W-1:0]    key_r, key_nxt;

  logic                          is_note;
  logic [mnds_pkg::STATUS_W-1:0] kind;
  logic [PR_W-1:0]               recip_prod;
  logic [mnds_pkg::DELTA_W-1:0]  len_sat;

  assign kind       = in_ch.status_byte & mnds_pkg::STATUS_KIND_MASK;
  assign is_note    = (kind == mnds_pkg::STATUS_NOTE_OFF) ||
                      (kind == mnds_pkg::STATUS_NOTE_ON);
  assign recip_prod = PR_W'(num_r) * PR_W'(RECIP);

  // saturate the rounded length to the field width
  assign len_sat = (prod_r > PROD_W'(mnds_pkg::LEN_MAX)) ? mnds_pkg::LEN_MAX
                                                         : prod_r[mnds_pkg::DELTA_W-1:0];

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign push_valid       = (state_r == ST_PUSH) && (len_sat != '0);
  assign push_data.is_on  = is_on_r;
  assign push_data.key    = key_r;
  assign push_data.len    = len_sat;

  // sequencer: accept, divide, scale, push
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    prod_nxt  = prod_r;
    is_on_nxt = is_on_r;
    key_nxt   = key_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && is_note) begin
          num_nxt   = {1'b0, in_ch.delta_ticks, 1'b0} + NUM_W'(GRANULE_TICKS);
          is_on_nxt = (kind == mnds_pkg::STATUS_NOTE_ON) && (in_ch.velocity != '0);
          key_nxt   = in_ch.key_number;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // quotient by 2*G through the reciprocal
        num_nxt   = NUM_W'(recip_prod[PR_W-1:SHIFT]);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(num_r) * PROD_W'(G_CONST);
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        // zero length gives nothing
        if ((len_sat == '0) || push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r   <= num_nxt;
    prod_r  <= prod_nxt;
    is_on_r <= is_on_nxt;
    key_r   <= key_nxt;
  end

endmodule

FILE: src/mnds_queue.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: command queue
// Short FIFO of classified events between the front and back ends.
// ----------------------------------------------------------------------------
module mnds_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  mnds_pkg::cmd_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output mnds_pkg::cmd_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int DEPTH = mnds_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mnds_pkg::cmd_t    entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/mnds_back.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: back end
// Splits each queued length into note or rest values: shift search one step
// a cycle, bit-serial dot division, then a registered result stage.
// ----------------------------------------------------------------------------
module mnds_back #(
  parameter int MAX_PARTS = mnds_pkg::MAX_PARTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mnds_pkg::TPQ_W-1:0] tpq,
  input  mnds_pkg::cmd_t             pop_data,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  mnds_out_if.source                 out_ch
);

  localparam int CNT_W  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int STEP_W = $clog2(mnds_pkg::DOTS_W + 1);
  localparam int LEN_W  = mnds_pkg::DELTA_W;
  localparam int HW     = mnds_pkg::HALF_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                         state_r, state_nxt;
  logic [LEN_W-1:0]                   len_r, len_nxt;
  logic                               is_on_r, is_on_nxt;
  logic [mnds_pkg::KEY_W-1:0]         key_r, key_nxt;
  logic [mnds_pkg::NOTE_VALUE_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [mnds_pkg::DOTS_W-1:0]        dq_r, dq_nxt;
  logic [HW-1:0]                      rem_r, rem_nxt;
  logic [STEP_W-1:0]                  step_r, step_nxt;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_is_rest_r;
  logic [mnds_pkg::KEY_W-1:0]         out_pitch_r;
  logic [mnds_pkg::NOTE_VALUE_W-1:0]  out_note_value_r;
  logic [mnds_pkg::DOTS_W-1:0]        out_dots_r;
  logic                               out_last_r;

  logic [mnds_pkg::WHOLE_W-1:0]       whole, base;
  logic [HW-1:0]                      half;
  logic [LEN_W-1:0]                   left;
  logic [HW:0]                        trial;
  logic                               load_out, is_last;

  assign whole    = {tpq, 2'b00};
  assign base     = whole >> n_r;
  assign half     = base[mnds_pkg::WHOLE_W-1:1];
  assign left     = len_r - LEN_W'(base);
  assign trial    = {rem_r, dq_r[mnds_pkg::DOTS_W-1]};
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign is_last  = !is_on_r || (len_r == '0) || (cnt_r == CNT_W'(MAX_PARTS - 1));

  assign pop_ready = (state_r == ST_IDLE);

  // split sequencer
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    is_on_nxt = is_on_r;
    key_nxt   = key_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          len_nxt   = pop_data.len;
          is_on_nxt = pop_data.is_on;
          key_nxt   = pop_data.key;
          n_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        // longest whole-note shift not above the remaining length
        if ((n_r != mnds_pkg::MAX_SHIFT) && (LEN_W'(base) > len_r)) begin
          n_nxt = n_r + 1'b1;
        end else if (half == '0) begin
          // no dot fits a zero half value
          dq_nxt    = '0;
          len_nxt   = left;
          state_nxt = ST_EMIT;
        end else begin
          dq_nxt    = left;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(mnds_pkg::DOTS_W);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // dots = left / half, one bit a cycle; remainder is what stays
        if (trial >= {1'b0, half}) begin
          rem_nxt = HW'(trial - {1'b0, half});
          dq_nxt  = {dq_r[mnds_pkg::DOTS_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[HW-1:0];
          dq_nxt  = {dq_r[mnds_pkg::DOTS_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          len_nxt   = LEN_W'(rem_nxt);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            n_nxt     = '0;
            state_nxt = ST_SRCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r   <= len_nxt;
    is_on_r <= is_on_nxt;
    key_r   <= key_nxt;
    n_r     <= n_nxt;
    cnt_r   <= cnt_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_is_rest_r    <= is_on_r;
      out_pitch_r      <= is_on_r ? '0 : key_r;
      out_note_value_r <= n_r;
      out_dots_r       <= dq_r;
      out_last_r       <= is_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.is_rest    = out_is_rest_r;
  assign out_ch.pitch      = out_pitch_r;
  assign out_ch.note_value = out_note_value_r;
  assign out_ch.dot_count  = out_dots_r;
  assign out_ch.last_part  = out_last_r;

endmodule

FILE: src/midi_note_duration_splitter.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: top level
// Turns MIDI note events and their delta times into note and rest values.
// ----------------------------------------------------------------------------
// The block takes one event per item on in_ch and gives zero or more results
// on out_ch, the final one of an event flagged by last_part. Statuses other
// than note-on and note-off are dropped. A note event passes the front end
// in order (accept, reciprocal multiply for the division by twice the
// granule, scale by the granule, push); up to two rounded events then wait
// in a queue. The back end picks an event from the queue and then, per
// result, runs a shift search (a whole note is below 4096 ticks), a
// bit-serial dot division when the half value is nonzero and a load of the
// output register; a rest run has at most MAX_PARTS parts, and no new event
// is taken until the last result of the current one is loaded. Front and
// back work on different events at once. ticks_per_quarter is written over
// cfg_ch, always ready, and must only change while the block is idle. No
// clearing pass is needed after reset.
module midi_note_duration_splitter #(
  parameter int MAX_PARTS     = mnds_pkg::MAX_PARTS_DEF,
  parameter int GRANULE_TICKS = mnds_pkg::GRANULE_TICKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mnds_in_if.sink    in_ch,
  mnds_out_if.source out_ch,
  mnds_cfg_if.sink   cfg_ch
);

  logic [mnds_pkg::TPQ_W-1:0] tpq_r;
  mnds_pkg::cmd_t             push_data, pop_data;
  logic                       push_valid, push_ready;
  logic                       pop_valid, pop_ready;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r <= mnds_pkg::TPQ_RESET;
    end else if (cfg_ch.valid) begin
      tpq_r <= cfg_ch.ticks_per_quarter;
    end
  end

  mnds_front #(
    .GRANULE_TICKS(GRANULE_TICKS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  mnds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  mnds_back #(
    .MAX_PARTS(MAX_PARTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tpq      (tpq_r),
    .pop_data (pop_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .out_ch   (out_ch)
  );

endmodule

FILE: src/mnds_checker.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: port checker
// Watches the result port and flags values the block must never show.
// ----------------------------------------------------------------------------
`include "midi_note_duration_splitter_macros.svh"

module mnds_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_is_rest,
  input logic [mnds_pkg::KEY_W-1:0]        out_pitch,
  input logic [mnds_pkg::NOTE_VALUE_W-1:0] out_note_value,
  input logic [mnds_pkg::DOTS_W-1:0]       out_dot_count,
  input logic                              out_last_part
);

  // a stalled result holds
  `MNDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_is_rest) && $stable(out_pitch) && $stable(out_note_value) && $stable(out_dot_count) && $stable(out_last_part))

  // rests carry no pitch
  `MNDS_ASSERT_NOW(a_rest_no_pitch, clk, rst_n, out_valid && out_is_rest, out_pitch == '0)

  // a note value is always the only result of its event
  `MNDS_ASSERT_NOW(a_note_is_last, clk, rst_n, out_valid && !out_is_rest, out_last_part)

endmodule

bind midi_note_duration_splitter mnds_checker u_mnds_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_is_rest   (out_ch.is_rest),
  .out_pitch     (out_ch.pitch),
  .out_note_value(out_ch.note_value),
  .out_dot_count (out_ch.dot_count),
  .out_last_part (out_ch.last_part)
);

FILE: sim/tb_midi_note_duration_splitter.sv
// ----------------------------------------------------------------------------
// MIDI note duration splitter: testbench
// Sends MIDI events under several ticks-per-quarter settings: a directed table
// first, then random events. Each returned note or rest value is checked
// against its typed table row or a behavioral duration splitter in the bench.
// Both channels stall at random, but one random phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_midi_note_duration_splitter;

  localparam int        CLK_HALF     = 4;
  localparam int        RESET_CYCLES = 6;
  localparam int        IDLE_PCT     = 31;
  localparam int        SETTLE_CYCLES = 300;
  localparam int        CYCLE_LIMIT  = 1_000_000;
  localparam int        RAND_PHASES  = 6;
  localparam int        RAND_ITEMS   = 18;
  localparam int        MAX_PARTS    = mnds_pkg::MAX_PARTS_DEF;
  localparam bit [63:0] GRANULE      = mnds_pkg::GRANULE_TICKS_DEF;

  localparam bit [mnds_pkg::STATUS_W-1:0] ST_NOTE_OFF = mnds_pkg::STATUS_NOTE_OFF;
  localparam bit [mnds_pkg::STATUS_W-1:0] ST_NOTE_ON  = mnds_pkg::STATUS_NOTE_ON;
  localparam bit [mnds_pkg::STATUS_W-1:0] ST_MASK     = mnds_pkg::STATUS_KIND_MASK;

  // statuses that are neither note-on nor note-off
  localparam bit [mnds_pkg::STATUS_W-1:0] ST_SYSEX      = 8'hF0;
  localparam bit [mnds_pkg::STATUS_W-1:0] ST_META       = 8'hFF;
  localparam bit [mnds_pkg::STATUS_W-1:0] ST_AFTERTOUCH = 8'hA5;
  localparam bit [mnds_pkg::STATUS_W-1:0] ST_DATA_BYTE  = 8'h7F;

  typedef struct packed {
    bit [mnds_pkg::STATUS_W-1:0] status;
    bit [mnds_pkg::KEY_W-1:0]    key;
    bit [mnds_pkg::VEL_W-1:0]    vel;
    bit [mnds_pkg::DELTA_W-1:0]  delta;
  } midi_event_t;

  typedef struct packed {
    bit                              is_rest;
    bit [mnds_pkg::KEY_W-1:0]        pitch;
    bit [mnds_pkg::NOTE_VALUE_W-1:0] note_value;
    bit [mnds_pkg::DOTS_W-1:0]       dot_count;
    bit                              last_part;
  } part_t;

  typedef enum bit [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    bit [mnds_pkg::TPQ_W-1:0]  tpq;
    midi_event_t               ev;
    bit                        has_part;
    part_t                     part;
  } row_t;

  // directed table; typed rows carry their single result, or none
  localparam row_t DIRECTED [22] = '{
    // resolution 384 after reset: whole note is 1536 ticks
    '{ROW_TYPED, 10'd0, '{ST_NOTE_OFF, 7'd60, 7'd64, 28'd1536}, 1'b1,
      '{1'b0, 7'd60, 4'd0, 28'd0, 1'b1}},
    // note-on with zero velocity acts as note-off
    '{ROW_TYPED, 10'd0, '{ST_NOTE_ON, 7'd0, 7'd0, 28'd1536}, 1'b1,
      '{1'b0, 7'd0, 4'd0, 28'd0, 1'b1}},
    '{ROW_TYPED, 10'd0, '{ST_NOTE_ON, 7'd64, 7'd100, 28'd1536}, 1'b1,
      '{1'b1, 7'd0, 4'd0, 28'd0, 1'b1}},
    // dotted whole rest
    '{ROW_TYPED, 10'd0, '{ST_NOTE_ON | 8'h0F, 7'd127, 7'd127, 28'd2304}, 1'b1,
      '{1'b1, 7'd0, 4'd0, 28'd1, 1'b1}},
    // 24 ticks is half a granule and rounds up to 48
    '{ROW_TYPED, 10'd0, '{ST_NOTE_OFF | 8'h0F, 7'd127, 7'd0, 28'd24}, 1'b1,
      '{1'b0, 7'd127, 4'd5, 28'd0, 1'b1}},
    // zero rounded delta gives nothing
    '{ROW_TYPED, 10'd0, '{ST_NOTE_OFF, 7'd127, 7'd127, 28'd23}, 1'b0, '0},
    '{ROW_TYPED, 10'd0, '{ST_NOTE_ON | 8'h01, 7'd1, 7'd1, 28'd0}, 1'b0, '0},
    // other statuses are dropped
    '{ROW_TYPED, 10'd0, '{ST_SYSEX, 7'd0, 7'd0, 28'd1536}, 1'b0, '0},
    '{ROW_TYPED, 10'd0, '{ST_META, 7'd127, 7'd127, 28'h0FFFFFFF}, 1'b0, '0},
    '{ROW_TYPED, 10'd0, '{ST_DATA_BYTE, 7'd127, 7'd127, 28'h0FFFFFFF}, 1'b0, '0},
    '{ROW_TYPED, 10'd0, '{ST_AFTERTOUCH, 7'd42, 7'd85, 28'h5555555}, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_ON, 7'd5, 7'd127, 28'h0FFFFFFF}, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_OFF | 8'h05, 7'd85, 7'd42, 28'hAAAAAAA}, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_ON | 8'h03, 7'd42, 7'd85, 28'd1500}, 1'b0, '0},
    // low resolution: 24 ticks per quarter
    '{ROW_CFG, 10'd24, '0, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_ON, 7'd9, 7'd1, 28'd1000}, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_OFF, 7'd99, 7'd9, 28'h0FFFFFFF}, 1'b0, '0},
    // high resolution: 960 ticks per quarter
    '{ROW_CFG, 10'd960, '0, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_ON | 8'h0A, 7'd3, 7'd77, 28'h3FFF}, 1'b0, '0},
    // zero resolution: rests consume nothing, so the run hits the part cap
    '{ROW_CFG, 10'd0, '0, 1'b0, '0},
    '{ROW_PREDICT, 10'd0, '{ST_NOTE_ON, 7'd8, 7'd1, 28'd48}, 1'b0, '0},
    '{ROW_TYPED, 10'd0, '{ST_NOTE_OFF, 7'd7, 7'd0, 28'd48}, 1'b1,
      '{1'b0, 7'd7, 4'd0, 28'd0, 1'b1}}
  };

  logic clk;
  logic rst_n;

  mnds_in_if  in_ch ();
  mnds_out_if out_ch ();
  mnds_cfg_if cfg_ch ();

  midi_note_duration_splitter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // splitter state as the bench sees it
  bit [mnds_pkg::TPQ_W-1:0]   cur_tpq;
  bit [mnds_pkg::DELTA_W-1:0] rem_ticks;
  bit [4:0]                   parts_done;

  part_t event_values [$];   // values of the event just accepted
  part_t awaited_values [$]; // values not yet returned by the block
  int    n_errors;
  int    n_cycles;
  bit    no_stall;

  // one value out of span: longest whole-note shift, then dots of half of it
  function automatic bit [63:0] split_span(input bit [63:0] span,
                                           output bit [mnds_pkg::NOTE_VALUE_W-1:0] shift,
                                           output bit [63:0] dots);
    bit [63:0]   whole;
    bit [63:0]   base;
    bit [63:0]   half;
    int unsigned n;
    whole = {52'd0, cur_tpq, 2'b00};
    n = 0;
    while (n < 15 && (whole >> n) > span) n++;
    base = whole >> n;
    half = whole >> (n + 1);
    dots = 0;
    // a zero half allows no dot
    if (half != 0) dots = (span - base) / half;
    shift = n[mnds_pkg::NOTE_VALUE_W-1:0];
    return base + dots * half;
  endfunction

  // all note or rest values caused by one event, into event_values
  function automatic void split_event(input midi_event_t ev);
    bit [mnds_pkg::STATUS_W-1:0]     kind;
    bit                              note_on;
    bit [63:0]                       span;
    bit [63:0]                       used;
    bit [63:0]                       dots;
    bit [mnds_pkg::NOTE_VALUE_W-1:0] shift;
    int                              count;
    event_values.delete();
    kind = ev.status & ST_MASK;
    if (kind != ST_NOTE_OFF && kind != ST_NOTE_ON) return;
    note_on = (kind == ST_NOTE_ON) && (ev.vel != 0);
    // round to the granule, halves up
    span = ((2 * {36'd0, ev.delta} + GRANULE) / (2 * GRANULE)) * GRANULE;
    if (span > {36'd0, mnds_pkg::LEN_MAX}) span = {36'd0, mnds_pkg::LEN_MAX};
    if (span == 0) begin
      rem_ticks = '0;
      parts_done = '0;
      return;
    end
    if (!note_on) begin
      used = split_span(span, shift, dots);
      event_values.push_back('{1'b0, ev.key, shift, dots[mnds_pkg::DOTS_W-1:0], 1'b1});
      rem_ticks = mnds_pkg::DELTA_W'(span - used);
      parts_done = 5'd1;
      return;
    end
    // rest run, capped at MAX_PARTS
    count = 0;
    while (span != 0 && count < MAX_PARTS) begin
      used = split_span(span, shift, dots);
      span -= used;
      count++;
      event_values.push_back('{1'b1, 7'd0, shift, dots[mnds_pkg::DOTS_W-1:0],
                               (span == 0 || count == MAX_PARTS)});
    end
    rem_ticks = span[mnds_pkg::DELTA_W-1:0];
    parts_done = count[4:0];
  endfunction

  function automatic void report_part(input string what, input part_t want,
                                      input part_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t %s: exp rest=%0b pitch=%0d value=%0d dots=%0d last=%0b",
               $time, what, want.is_rest, want.pitch, want.note_value,
               want.dot_count, want.last_part,
               " / got rest=%0b pitch=%0d value=%0d dots=%0d last=%0b",
               got.is_rest, got.pitch, got.note_value, got.dot_count, got.last_part);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result check, oldest awaited value first
  always @(posedge clk) begin
    part_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.is_rest, out_ch.pitch, out_ch.note_value, out_ch.dot_count,
              out_ch.last_part};
      if (awaited_values.size() == 0) begin
        report_part("unexpected item", '0, got);
      end else begin
        if (got !== awaited_values[0]) report_part("mismatch", awaited_values[0], got);
        void'(awaited_values.pop_front());
      end
    end
  end

  // entered and left at a falling edge; valid stays high on exit
  task automatic send_item(input midi_event_t ev, input bit typed, input bit has_part,
                           input part_t part);
    while (!no_stall && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.status_byte = ev.status;
    in_ch.key_number  = ev.key;
    in_ch.velocity    = ev.vel;
    in_ch.delta_ticks = ev.delta;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    split_event(ev);
    if (typed) begin
      if (has_part) awaited_values.push_back(part);
    end else begin
      foreach (event_values[k]) awaited_values.push_back(event_values[k]);
    end
    @(negedge clk);
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    in_ch.valid = 1'b0;
    while (awaited_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_tpq(input bit [mnds_pkg::TPQ_W-1:0] value);
    settle();
    cfg_ch.valid             = 1'b1;
    cfg_ch.ticks_per_quarter = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cur_tpq = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // stimulus
  initial begin
    midi_event_t                 ev;
    int                          sent;
    int unsigned                 pick;
    bit [mnds_pkg::STATUS_W-1:0] kind;
    bit [mnds_pkg::TPQ_W-1:0]    tpq_pick;

    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.status_byte        = '0;
    in_ch.key_number         = '0;
    in_ch.velocity           = '0;
    in_ch.delta_ticks        = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.ticks_per_quarter = '0;
    no_stall                 = 1'b0;
    cur_tpq                  = mnds_pkg::TPQ_RESET;
    rem_ticks                = '0;
    parts_done               = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_tpq(DIRECTED[i].tpq);
      end else begin
        send_item(DIRECTED[i].ev, DIRECTED[i].kind == ROW_TYPED, DIRECTED[i].has_part,
                  DIRECTED[i].part);
      end
    end
    write_tpq(10'd1023);
    send_item('{ST_NOTE_ON | 8'h0E, 7'd64, 7'd64, 28'h0FFFFFFF}, 1'b0, 1'b0, '0);
    send_item('{ST_NOTE_OFF | 8'h0E, 7'd21, 7'd33, 28'h1234567}, 1'b0, 1'b0, '0);

    // random phases, one of them without any stalls
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        1:       tpq_pick = 10'd24;
        3:       tpq_pick = 10'($urandom_range(0, 1023));
        4:       tpq_pick = 10'd960;
        default: tpq_pick = 10'($urandom_range(24, 960));
      endcase
      write_tpq(tpq_pick);
      no_stall = (ph == 2);
      sent = 0;
      while (sent < RAND_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          ev.status = ($urandom_range(0, 1) ? ST_NOTE_ON : ST_NOTE_OFF) |
                      8'($urandom_range(0, 15));
        end else begin
          ev.status = 8'($urandom);
          kind = ev.status & ST_MASK;
          while (kind == ST_NOTE_ON || kind == ST_NOTE_OFF) begin
            ev.status = 8'($urandom);
            kind = ev.status & ST_MASK;
          end
        end
        ev.key = 7'($urandom);
        ev.vel = ($urandom_range(0, 99) < 20) ? 7'd0 : 7'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
          ev.delta = 28'($urandom);
        else if (pick == 1)
          ev.delta = 28'($urandom_range(0, 40) * 48 + 23 + $urandom_range(0, 1));
        else
          ev.delta = 28'($urandom_range(0, 24 * cur_tpq + 100));
        send_item(ev, 1'b0, 1'b0, '0);
        kind = ev.status & ST_MASK;
        if (kind == ST_NOTE_ON || kind == ST_NOTE_OFF) sent++;
      end
    end
    no_stall = 1'b0;

    settle();
    if (n_errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: midi_note_duration_splitter.f
+incdir+src
src/mnds_pkg.sv
src/mnds_ifs.sv
src/mnds_front.sv
src/mnds_queue.sv
src/mnds_back.sv
src/midi_note_duration_splitter.sv
src/mnds_checker.sv
sim/tb_midi_note_duration_splitter.sv
